>>> rtl/rid_pkg.sv
// Shared constants, command codes and control types for the run-length image row decoder.
package rid_pkg;

	localparam int ROW_WIDTH      = 800;
	localparam int PIXEL_CAPACITY = 960000;

	localparam int POS_W  = $clog2(PIXEL_CAPACITY + 1);
	localparam int COL_W  = $clog2(ROW_WIDTH + 1);
	localparam int SUM_W  = ((POS_W > COL_W) ? POS_W : COL_W) + 1;
	localparam int CSUM_W = ((COL_W > 7) ? COL_W : 7) + 1;
	localparam int CNT_W  = 6;
	localparam int PIX_W  = 20;
	localparam int IN_W   = 8;
	localparam int OUT_W  = 56;

	localparam logic [7:0] CMD_ROW_SKIP = 8'hFF;
	localparam logic [7:0] CMD_SKIP_MIN = 8'h9F;
	localparam logic [7:0] CMD_SKIP_BAS = 8'h9E;
	localparam logic [7:0] CMD_RUN_MIN  = 8'h7F;
	localparam logic [7:0] CMD_RUN_BAS  = 8'h7E;
	localparam logic [7:0] ALPHA_RUN    = 8'hFF;

	localparam logic [1:0] PH_CMD = 2'd0;
	localparam logic [1:0] PH_C0  = 2'd1;
	localparam logic [1:0] PH_C1  = 2'd2;
	localparam logic [1:0] PH_C2  = 2'd3;

	typedef struct packed {
		logic take;
		logic load;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic color_phase;
		logic more;
		logic slot_free;
	} dp_stat_t;

endpackage

>>> rtl/rle_image_row_decoder.sv
// Sequence: a command or first/second color byte is taken on its own; a third color byte is
// followed by the pixel writes of its run (1 to 32) and a closing step.
// Throughput: one byte per cycle outside runs; a run holds the input until it is done,
// paced by the single output register: one pixel per cycle unless m_tready stalls it.
// Reset: arst_n clears parser state, position, column and output valid at once.
// A byte flagged as final returns the decoder to image start after its writes.
module rle_image_row_decoder import rid_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // [7:0] byte_in
	input  logic             s_tlast,  // last_byte
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // [19:0] pixel_index, [27:20] chan0, [35:28] chan1,
	                                   // [43:36] chan2, [51:44] alpha, [55:52] zero
	output logic             m_tlast   // last_of_run
);

	dp_cmd_t  cmd;
	dp_stat_t st;

	rid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	rid_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.cmd       (cmd),
		.st        (st),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

	a_load_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!m_tvalid || m_tready))
		else $error("pixel loaded over an untaken transfer");

	a_run_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && st.color_phase) |=> !s_tready)
		else $error("input taken while a run is pending");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((POS_W + 1)'(m_tdata[PIX_W-1:0]) < (POS_W + 1)'(PIXEL_CAPACITY)))
		else $error("pixel write beyond frame capacity");

endmodule

>>> rtl/rid_ctrl.sv
// Controller: alternates between taking stream bytes and emitting a pending run of pixels.
module rid_ctrl import rid_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t st,
	output dp_cmd_t  cmd
);

	localparam logic ST_TAKE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.take   = 1'b0;
		cmd.load   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			ST_TAKE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && st.color_phase) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (st.more) begin
					cmd.load = st.slot_free;
				end else begin
					cmd.finish = 1'b1;
					state_d    = ST_TAKE;
				end
			end
			default: begin
				state_d = ST_TAKE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TAKE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/rid_dp.sv
// Datapath: parser state, write position, row column, run counter and output register.
module rid_dp import rid_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IN_W-1:0]  in_byte,
	input  logic             in_last,
	input  dp_cmd_t          cmd,
	output dp_stat_t         st,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [OUT_W-1:0] out_data,
	output logic             out_last
);

	logic [1:0]       phase_q;
	logic [CNT_W-1:0] pcount_q;
	logic [7:0]       palpha_q;
	logic [7:0]       color0_q;
	logic [7:0]       color1_q;
	logic [7:0]       color2_q;
	logic [POS_W-1:0] wp_q;
	logic [COL_W-1:0] col_q;
	logic [POS_W-1:0] epos_q;
	logic [CNT_W-1:0] remain_q;
	logic             last_pend_q;

	logic             ovalid_q;
	logic [PIX_W-1:0] opix_q;
	logic [7:0]       oc0_q;
	logic [7:0]       oc1_q;
	logic [7:0]       oc2_q;
	logic [7:0]       oalpha_q;
	logic             olast_q;

	logic [6:0]       skip_n;
	logic [CNT_W-1:0] run_n;

	function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W-1:0] p,
			input logic [SUM_W-1:0] n);
		logic [SUM_W:0] s;
		s = {1'b0, SUM_W'(p)} + {1'b0, n};
		if (s > (SUM_W + 1)'(PIXEL_CAPACITY)) begin
			sat_pos = POS_W'(PIXEL_CAPACITY);
		end else begin
			sat_pos = s[POS_W-1:0];
		end
	endfunction

	function automatic logic [COL_W-1:0] sat_col(input logic [COL_W-1:0] c,
			input logic [6:0] n);
		logic [CSUM_W-1:0] s;
		s = CSUM_W'(c) + CSUM_W'(n);
		if (s > CSUM_W'(ROW_WIDTH)) begin
			sat_col = COL_W'(ROW_WIDTH);
		end else begin
			sat_col = s[COL_W-1:0];
		end
	endfunction

	assign skip_n = 7'(in_byte - CMD_SKIP_BAS);
	assign run_n  = CNT_W'(in_byte - CMD_RUN_BAS);

	assign st.color_phase = (phase_q == PH_C2);
	assign st.more        = (remain_q != '0) && (epos_q < POS_W'(PIXEL_CAPACITY));
	assign st.slot_free   = !ovalid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CMD;
			pcount_q    <= '0;
			palpha_q    <= '0;
			color0_q    <= '0;
			color1_q    <= '0;
			wp_q        <= '0;
			col_q       <= '0;
			epos_q      <= '0;
			remain_q    <= '0;
			last_pend_q <= 1'b0;
		end else if (cmd.take && in_last && (phase_q != PH_C2)) begin
			// final byte other than a third color byte: drop back to image start
			phase_q  <= PH_CMD;
			pcount_q <= '0;
			palpha_q <= '0;
			color0_q <= '0;
			color1_q <= '0;
			wp_q     <= '0;
			col_q    <= '0;
		end else if (cmd.take) begin
			case (phase_q)
				PH_CMD: begin
					if (in_byte == CMD_ROW_SKIP) begin
						wp_q  <= sat_pos(wp_q, SUM_W'(COL_W'(ROW_WIDTH) - col_q));
						col_q <= '0;
					end else if (in_byte >= CMD_SKIP_MIN) begin
						wp_q  <= sat_pos(wp_q, SUM_W'(skip_n));
						col_q <= sat_col(col_q, skip_n);
					end else if (in_byte >= CMD_RUN_MIN) begin
						pcount_q <= run_n;
						palpha_q <= ALPHA_RUN;
						phase_q  <= PH_C0;
					end else begin
						pcount_q <= CNT_W'(1);
						palpha_q <= {in_byte[6:0], 1'b0};
						phase_q  <= PH_C0;
					end
				end
				PH_C0: begin
					color0_q <= in_byte;
					phase_q  <= PH_C1;
				end
				PH_C1: begin
					color1_q <= in_byte;
					phase_q  <= PH_C2;
				end
				PH_C2: begin
					epos_q      <= wp_q;
					remain_q    <= pcount_q;
					last_pend_q <= in_last;
				end
				default: begin
					phase_q <= PH_CMD;
				end
			endcase
		end else if (cmd.load) begin
			epos_q   <= epos_q + POS_W'(1);
			remain_q <= remain_q - CNT_W'(1);
		end else if (cmd.finish) begin
			if (last_pend_q) begin
				phase_q  <= PH_CMD;
				pcount_q <= '0;
				palpha_q <= '0;
				color0_q <= '0;
				color1_q <= '0;
				wp_q     <= '0;
				col_q    <= '0;
			end else begin
				phase_q <= PH_CMD;
				wp_q    <= epos_q;
				col_q   <= sat_col(col_q, 7'(pcount_q));
			end
			last_pend_q <= 1'b0;
		end
	end

	// third color byte holds for the whole run
	always_ff @(posedge clk) begin
		if (cmd.take && (phase_q == PH_C2)) begin
			color2_q <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.load) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			opix_q   <= PIX_W'(epos_q);
			oc0_q    <= color0_q;
			oc1_q    <= color1_q;
			oc2_q    <= color2_q;
			oalpha_q <= palpha_q;
			olast_q  <= (remain_q == CNT_W'(1)) ||
				(epos_q == POS_W'(PIXEL_CAPACITY - 1));
		end
	end

	assign out_valid = ovalid_q;
	assign out_data  = {4'b0000, oalpha_q, oc2_q, oc1_q, oc0_q, opix_q};
	assign out_last  = olast_q;

endmodule
